/* rtl/core/q24alu_pkg.sv */
// Shared constants, action and status codes, and the sideband type of the Q24.8 ALU.
package q24alu_pkg;

  // Default format: 32-bit raw word, 8 fraction bits
  localparam int FRAC_BITS_DEF = 8;
  localparam int WORD_BITS_DEF = 32;

  localparam int ACT_W    = 4;
  localparam int STATUS_W = 2;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_ADD    = 4'd0;
  localparam logic [ACT_W-1:0] ACT_SUB    = 4'd1;
  localparam logic [ACT_W-1:0] ACT_MUL    = 4'd2;
  localparam logic [ACT_W-1:0] ACT_DIV    = 4'd3;
  localparam logic [ACT_W-1:0] ACT_GT     = 4'd4;
  localparam logic [ACT_W-1:0] ACT_LT     = 4'd5;
  localparam logic [ACT_W-1:0] ACT_GE     = 4'd6;
  localparam logic [ACT_W-1:0] ACT_LE     = 4'd7;
  localparam logic [ACT_W-1:0] ACT_EQ     = 4'd8;
  localparam logic [ACT_W-1:0] ACT_NE     = 4'd9;
  localparam logic [ACT_W-1:0] ACT_MIN    = 4'd10;
  localparam logic [ACT_W-1:0] ACT_MAX    = 4'd11;
  localparam logic [ACT_W-1:0] ACT_INC    = 4'd12;
  localparam logic [ACT_W-1:0] ACT_DEC    = 4'd13;
  localparam logic [ACT_W-1:0] ACT_TO_INT = 4'd14;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVF  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DIVZ = 2'd2;

  // Per-word control that rides along the pipeline
  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic                compare_true;
    logic [STATUS_W-1:0] status;
  } side_t;

endpackage

/* rtl/core/q24alu_if.sv */
// Valid/ready channel interfaces for the operation words and the result words.
interface q24alu_in_if #(
  parameter int WORD_BITS = q24alu_pkg::WORD_BITS_DEF
) ();
  import q24alu_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [ACT_W-1:0]            action;
  logic signed [WORD_BITS-1:0] operand_a;
  logic signed [WORD_BITS-1:0] operand_b;

  modport source (output valid, action, operand_a, operand_b, input ready);
  modport sink   (input valid, action, operand_a, operand_b, output ready);
endinterface

interface q24alu_out_if #(
  parameter int WORD_BITS = q24alu_pkg::WORD_BITS_DEF
) ();
  import q24alu_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] result_value;
  logic                        compare_true;
  logic [STATUS_W-1:0]         status;

  modport source (output valid, result_value, compare_true, status, input ready);
  modport sink   (input valid, result_value, compare_true, status, output ready);
endinterface

/* rtl/core/q24alu_prep.sv */
// Input stage: operand magnitudes and the actions finished here (add, sub, inc, dec, compare, min, max, to_int).
module q24alu_prep #(
  parameter int FRAC_BITS = q24alu_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = q24alu_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [q24alu_pkg::ACT_W-1:0]  action,
  input  logic signed [WORD_BITS-1:0]   operand_a,
  input  logic signed [WORD_BITS-1:0]   operand_b,
  output q24alu_pkg::side_t             side_o,
  output logic [WORD_BITS-1:0]          value_o,
  output logic [WORD_BITS-1:0]          mag_a_o,
  output logic [WORD_BITS-1:0]          mag_b_o,
  output logic                          sign_a_o,
  output logic                          sign_b_o
);
  import q24alu_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int XW = W + 1;
  localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NEG_MIN = {1'b1, {(W-1){1'b0}}};

  logic [XW-1:0] a_x, b_x, sum_x, diff_x, inc_x, dec_x;
  logic [W-1:0]  mag_a, mag_b, int_rnd, int_mag, int_val;
  logic          gt, lt, eq;
  logic          ovf;
  logic [W-1:0]  fit_val;
  side_t         side_nxt;
  logic [W-1:0]  value_nxt;

  side_t         side_r;
  logic [W-1:0]  value_r, mag_a_r, mag_b_r;
  logic          sign_a_r, sign_b_r;

  // Saturate an exact (W+1)-bit result to the word; top bit of return is overflow
  function automatic logic [W:0] fit(input logic [XW-1:0] x);
    if (x[XW-1] != x[XW-2]) begin
      return {1'b1, (x[XW-1] ? NEG_MIN : POS_MAX)};
    end
    return {1'b0, x[W-1:0]};
  endfunction

  // Exact sums and differences one bit wider than the word
  assign a_x    = {operand_a[W-1], operand_a};
  assign b_x    = {operand_b[W-1], operand_b};
  assign sum_x  = a_x + b_x;
  assign diff_x = a_x - b_x;
  assign inc_x  = a_x + XW'(1);
  assign dec_x  = a_x - XW'(1);

  assign gt = operand_b < operand_a;
  assign lt = operand_a < operand_b;
  assign eq = operand_a == operand_b;

  // Magnitudes; the most negative word maps to 2^(W-1), which still fits unsigned
  assign mag_a = operand_a[W-1] ? (~operand_a + W'(1)) : operand_a;
  assign mag_b = operand_b[W-1] ? (~operand_b + W'(1)) : operand_b;

  // Round to integer, ties away from zero
  assign int_rnd = mag_a + (W'(1) << (FRAC_BITS - 1));
  assign int_mag = int_rnd >> FRAC_BITS;
  assign int_val = operand_a[W-1] ? (~int_mag + W'(1)) : int_mag;

  // Decode the action; multiply and divide are finished downstream
  always_comb begin
    side_nxt.action       = action;
    side_nxt.compare_true = 1'b0;
    side_nxt.status       = ST_OK;
    value_nxt             = '0;
    ovf                   = 1'b0;
    fit_val               = '0;
    unique case (action)
      ACT_ADD: begin
        {ovf, fit_val}  = fit(sum_x);
        value_nxt       = fit_val;
        side_nxt.status = ovf ? ST_OVF : ST_OK;
      end
      ACT_SUB: begin
        {ovf, fit_val}  = fit(diff_x);
        value_nxt       = fit_val;
        side_nxt.status = ovf ? ST_OVF : ST_OK;
      end
      ACT_INC: begin
        {ovf, fit_val}  = fit(inc_x);
        value_nxt       = fit_val;
        side_nxt.status = ovf ? ST_OVF : ST_OK;
      end
      ACT_DEC: begin
        {ovf, fit_val}  = fit(dec_x);
        value_nxt       = fit_val;
        side_nxt.status = ovf ? ST_OVF : ST_OK;
      end
      ACT_GT:     side_nxt.compare_true = gt;
      ACT_LT:     side_nxt.compare_true = lt;
      ACT_GE:     side_nxt.compare_true = !lt;
      ACT_LE:     side_nxt.compare_true = !gt;
      ACT_EQ:     side_nxt.compare_true = eq;
      ACT_NE:     side_nxt.compare_true = !eq;
      ACT_MIN:    value_nxt = gt ? operand_b : operand_a;
      ACT_MAX:    value_nxt = lt ? operand_b : operand_a;
      ACT_TO_INT: value_nxt = int_val;
      default: begin
      end
    endcase
  end

  // Load the stage when it advances
  always_ff @(posedge clk) begin
    if (en) begin
      side_r   <= side_nxt;
      value_r  <= value_nxt;
      mag_a_r  <= mag_a;
      mag_b_r  <= mag_b;
      sign_a_r <= operand_a[W-1];
      sign_b_r <= operand_b[W-1];
    end
  end

  assign side_o   = side_r;
  assign value_o  = value_r;
  assign mag_a_o  = mag_a_r;
  assign mag_b_o  = mag_b_r;
  assign sign_a_o = sign_a_r;
  assign sign_b_o = sign_b_r;

endmodule

/* rtl/core/q24alu_mul.sv */
// Multiplier pipeline: split partial products, sum, round and saturate, then align.
module q24alu_mul #(
  parameter int FRAC_BITS = q24alu_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = q24alu_pkg::WORD_BITS_DEF,
  parameter int DEPTH     = WORD_BITS + FRAC_BITS + 1
) (
  input  logic                 clk,
  input  logic [DEPTH-1:0]     en,
  input  logic [WORD_BITS-1:0] mag_a_i,
  input  logic [WORD_BITS-1:0] mag_b_i,
  input  logic                 neg_i,
  output logic [WORD_BITS-1:0] prod_o,
  output logic                 ovf_o
);
  localparam int W  = WORD_BITS;
  localparam int H  = (W + 1) / 2;
  localparam int HH = W - H;
  localparam int PW = 2 * W;

  logic [2*H-1:0]    ll_r;
  logic [H+HH-1:0]   lh_r, hl_r;
  logic [2*HH-1:0]   hh_r;
  logic              neg0_r, neg1_r;
  logic [PW-1:0]     sum_r;

  logic [PW-1:0]     sum_nxt, rnd, shd, lim;
  logic              ovf_nxt;
  logic [W-1:0]      mag, prod_nxt;

  logic [W-1:0]      res_r [2:DEPTH-1];
  logic              ovf_r [2:DEPTH-1];

  // Sum of the four partial products
  assign sum_nxt = PW'(ll_r) + (PW'(lh_r) << H) + (PW'(hl_r) << H) + (PW'(hh_r) << (2 * H));

  // Round half away from zero on the magnitude, then saturate by sign
  assign rnd      = sum_r + (PW'(1) << (FRAC_BITS - 1));
  assign shd      = rnd >> FRAC_BITS;
  assign lim      = neg1_r ? (PW'(1) << (W - 1)) : ((PW'(1) << (W - 1)) - PW'(1));
  assign ovf_nxt  = shd > lim;
  assign mag      = ovf_nxt ? lim[W-1:0] : shd[W-1:0];
  assign prod_nxt = neg1_r ? (~mag + W'(1)) : mag;

  always_ff @(posedge clk) begin
    // Partial products of half-width pieces
    if (en[0]) begin
      ll_r   <= mag_a_i[H-1:0] * mag_b_i[H-1:0];
      lh_r   <= mag_a_i[H-1:0] * mag_b_i[W-1:H];
      hl_r   <= mag_a_i[W-1:H] * mag_b_i[H-1:0];
      hh_r   <= mag_a_i[W-1:H] * mag_b_i[W-1:H];
      neg0_r <= neg_i;
    end
    if (en[1]) begin
      sum_r  <= sum_nxt;
      neg1_r <= neg0_r;
    end
    if (en[2]) begin
      res_r[2] <= prod_nxt;
      ovf_r[2] <= ovf_nxt;
    end
    // Delay to the divider's depth
    for (int k = 3; k < DEPTH; k++) begin
      if (en[k]) begin
        res_r[k] <= res_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign prod_o = res_r[DEPTH-1];
  assign ovf_o  = ovf_r[DEPTH-1];

endmodule

/* rtl/core/q24alu_div.sv */
// Divider pipeline: one restoring quotient bit per stage, then round, saturate and sign.
module q24alu_div #(
  parameter int FRAC_BITS = q24alu_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = q24alu_pkg::WORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic [WORD_BITS+FRAC_BITS:0]       en,
  input  q24alu_pkg::side_t                  side_i,
  input  logic [WORD_BITS-1:0]               value_i,
  input  logic [WORD_BITS-1:0]               mag_a_i,
  input  logic [WORD_BITS-1:0]               mag_b_i,
  input  logic                               sign_a_i,
  input  logic                               sign_b_i,
  output q24alu_pkg::side_t                  side_o,
  output logic [WORD_BITS-1:0]               value_o,
  output logic [WORD_BITS-1:0]               quot_o,
  output logic [q24alu_pkg::STATUS_W-1:0]    status_o
);
  import q24alu_pkg::*;

  localparam int W = WORD_BITS;
  localparam int N = WORD_BITS + FRAC_BITS;
  localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NEG_MIN = {1'b1, {(W-1){1'b0}}};

  // Per-step registers; the numerator shifts out as the quotient shifts in
  logic [W-1:0] rem_r  [0:N-1];
  logic [N-1:0] nq_r   [0:N-1];
  logic [W-1:0] den_r  [0:N-1];
  logic         neg_r  [0:N-1];
  logic         asg_r  [0:N-1];
  side_t        side_r [0:N-1];
  logic [W-1:0] val_r  [0:N-1];

  logic [N-1:0]          q, q_rnd, lim;
  logic                  round_up, ovf;
  logic [W-1:0]          mag, quot_nxt;
  logic [STATUS_W-1:0]   status_nxt;

  side_t                 fin_side_r;
  logic [W-1:0]          fin_val_r, fin_quot_r;
  logic [STATUS_W-1:0]   fin_status_r;

  // One restoring step: shift in a numerator bit, subtract if it fits
  function automatic logic [W+N-1:0] div_step(input logic [W-1:0] rem,
                                               input logic [N-1:0] nq,
                                               input logic [W-1:0] den);
    logic [W-1:0] sh;
    logic         ge;
    sh = {rem[W-2:0], nq[N-1]};
    ge = sh >= den;
    return {(ge ? sh - den : sh), nq[N-2:0], ge};
  endfunction

  // Advance the bit stages
  always_ff @(posedge clk) begin
    if (en[0]) begin
      {rem_r[0], nq_r[0]} <= div_step(W'(0), {mag_a_i, {FRAC_BITS{1'b0}}}, mag_b_i);
      den_r[0]  <= mag_b_i;
      neg_r[0]  <= sign_a_i ^ sign_b_i;
      asg_r[0]  <= sign_a_i;
      side_r[0] <= side_i;
      val_r[0]  <= value_i;
    end
    for (int k = 1; k < N; k++) begin
      if (en[k]) begin
        {rem_r[k], nq_r[k]} <= div_step(rem_r[k-1], nq_r[k-1], den_r[k-1]);
        den_r[k]  <= den_r[k-1];
        neg_r[k]  <= neg_r[k-1];
        asg_r[k]  <= asg_r[k-1];
        side_r[k] <= side_r[k-1];
        val_r[k]  <= val_r[k-1];
      end
    end
  end

  // Round to nearest (2r >= d), saturate, apply sign; zero divisor saturates by sign of a
  assign q        = nq_r[N-1];
  assign round_up = {rem_r[N-1], 1'b0} >= {1'b0, den_r[N-1]};
  assign q_rnd    = q + N'(round_up);
  assign lim      = neg_r[N-1] ? (N'(1) << (W - 1)) : ((N'(1) << (W - 1)) - N'(1));
  assign ovf      = q_rnd > lim;
  assign mag      = ovf ? lim[W-1:0] : q_rnd[W-1:0];

  always_comb begin
    if (den_r[N-1] == '0) begin
      quot_nxt   = asg_r[N-1] ? NEG_MIN : POS_MAX;
      status_nxt = ST_DIVZ;
    end else begin
      quot_nxt   = neg_r[N-1] ? (~mag + W'(1)) : mag;
      status_nxt = ovf ? ST_OVF : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en[N]) begin
      fin_side_r   <= side_r[N-1];
      fin_val_r    <= val_r[N-1];
      fin_quot_r   <= quot_nxt;
      fin_status_r <= status_nxt;
    end
  end

  assign side_o   = fin_side_r;
  assign value_o  = fin_val_r;
  assign quot_o   = fin_quot_r;
  assign status_o = fin_status_r;

endmodule

/* rtl/core/q24alu_ctrl.sv */
// Pipeline control: per-stage valid bits and load enables that close up bubbles.
module q24alu_ctrl #(
  parameter int STAGES = q24alu_pkg::WORD_BITS_DEF + q24alu_pkg::FRAC_BITS_DEF + 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_ready,
  output logic              in_ready,
  output logic              out_valid,
  output logic [STAGES-1:0] en
);
  logic [STAGES-1:0] vld_r;

  // Last stage loads when empty or taken; others also when they or a later stage is empty
  assign en[STAGES-1] = !vld_r[STAGES-1] || out_ready;
  for (genvar k = 0; k < STAGES - 1; k++) begin : g_en
    assign en[k] = en[STAGES-1] || !(&vld_r[STAGES-2:k]);
  end

  // Move valid bits with the words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[STAGES-1];

endmodule

/* rtl/core/q24alu_out.sv */
// Output stage: pick the unit that finished the action and hold the result word.
module q24alu_out #(
  parameter int WORD_BITS = q24alu_pkg::WORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  q24alu_pkg::side_t                side_i,
  input  logic [WORD_BITS-1:0]             value_i,
  input  logic [WORD_BITS-1:0]             quot_i,
  input  logic [q24alu_pkg::STATUS_W-1:0]  quot_status_i,
  input  logic [WORD_BITS-1:0]             prod_i,
  input  logic                             prod_ovf_i,
  output logic signed [WORD_BITS-1:0]      result_value,
  output logic                             compare_true,
  output logic [q24alu_pkg::STATUS_W-1:0]  status
);
  import q24alu_pkg::*;

  logic [WORD_BITS-1:0] value_nxt;
  logic                 cmp_nxt;
  logic [STATUS_W-1:0]  status_nxt;

  logic [WORD_BITS-1:0] value_r;
  logic                 cmp_r;
  logic [STATUS_W-1:0]  status_r;

  // Select the finished result
  always_comb begin
    case (side_i.action)
      ACT_MUL: begin
        value_nxt  = prod_i;
        cmp_nxt    = 1'b0;
        status_nxt = prod_ovf_i ? ST_OVF : ST_OK;
      end
      ACT_DIV: begin
        value_nxt  = quot_i;
        cmp_nxt    = 1'b0;
        status_nxt = quot_status_i;
      end
      default: begin
        value_nxt  = value_i;
        cmp_nxt    = side_i.compare_true;
        status_nxt = side_i.status;
      end
    endcase
  end

  // Hold the word until the receiver takes it
  always_ff @(posedge clk) begin
    if (en) begin
      value_r  <= value_nxt;
      cmp_r    <= cmp_nxt;
      status_r <= status_nxt;
    end
  end

  assign result_value = value_r;
  assign compare_true = cmp_r;
  assign status       = status_r;

endmodule

/* rtl/core/q24_8_fixed_point_alu.sv */
// Top level of the pipelined Q24.8 fixed-point ALU.
//
// The in_chan sink takes one operation word per cycle when ready: action,
// operand_a and operand_b (raw two's complement, FRAC_BITS fraction bits). The
// out_chan source returns one result word per operation, in order:
// result_value, compare_true and status (ok, overflow saturated, divide by
// zero). A word is taken at a clock edge where valid and ready are both high.
//
// Every action takes the same path through the pipeline. The depth is set by
// the divider, which resolves one quotient bit per stage; the input stage, the
// round/saturate stage and the output register add the rest. Multiply and
// the actions finished in the input stage are delayed to the same depth, so
// words leave in order. Throughput is one word per cycle while in_chan.ready
// is high.
//
// When the receiver stalls, the output word holds and the stages behind it
// keep filling empty slots; in_chan.ready drops only once every stage is full.
// A synchronous reset (rst_n low) empties the pipeline; no word is in flight.
module q24_8_fixed_point_alu #(
  parameter int FRAC_BITS = q24alu_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = q24alu_pkg::WORD_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  q24alu_in_if.sink       in_chan,
  q24alu_out_if.source    out_chan
);
  import q24alu_pkg::*;

  localparam int STEPS  = WORD_BITS + FRAC_BITS;
  localparam int STAGES = STEPS + 3;

  logic [STAGES-1:0]    stage_en;
  logic                 in_ready, out_valid;

  side_t                prep_side, div_side;
  logic [WORD_BITS-1:0] prep_value, mag_a, mag_b;
  logic                 sign_a, sign_b;
  logic [WORD_BITS-1:0] div_value, quot, prod;
  logic [STATUS_W-1:0]  quot_status;
  logic                 prod_ovf;

  q24alu_ctrl #(
    .STAGES (STAGES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .out_ready (out_chan.ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .en        (stage_en)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

  q24alu_prep #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_prep (
    .clk       (clk),
    .en        (stage_en[0]),
    .action    (in_chan.action),
    .operand_a (in_chan.operand_a),
    .operand_b (in_chan.operand_b),
    .side_o    (prep_side),
    .value_o   (prep_value),
    .mag_a_o   (mag_a),
    .mag_b_o   (mag_b),
    .sign_a_o  (sign_a),
    .sign_b_o  (sign_b)
  );

  q24alu_div #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_div (
    .clk      (clk),
    .en       (stage_en[STEPS+1:1]),
    .side_i   (prep_side),
    .value_i  (prep_value),
    .mag_a_i  (mag_a),
    .mag_b_i  (mag_b),
    .sign_a_i (sign_a),
    .sign_b_i (sign_b),
    .side_o   (div_side),
    .value_o  (div_value),
    .quot_o   (quot),
    .status_o (quot_status)
  );

  q24alu_mul #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS),
    .DEPTH     (STEPS + 1)
  ) u_mul (
    .clk     (clk),
    .en      (stage_en[STEPS+1:1]),
    .mag_a_i (mag_a),
    .mag_b_i (mag_b),
    .neg_i   (sign_a ^ sign_b),
    .prod_o  (prod),
    .ovf_o   (prod_ovf)
  );

  q24alu_out #(
    .WORD_BITS (WORD_BITS)
  ) u_out (
    .clk           (clk),
    .en            (stage_en[STAGES-1]),
    .side_i        (div_side),
    .value_i       (div_value),
    .quot_i        (quot),
    .quot_status_i (quot_status),
    .prod_i        (prod),
    .prod_ovf_i    (prod_ovf),
    .result_value  (out_chan.result_value),
    .compare_true  (out_chan.compare_true),
    .status        (out_chan.status)
  );

endmodule

/* rtl/core/q24alu_check.sv */
// Port-level assertions for the Q24.8 ALU, bound to the top level.
module q24alu_check #(
  parameter int WORD_BITS = q24alu_pkg::WORD_BITS_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [WORD_BITS-1:0]     result_value,
  input logic                            compare_true,
  input logic [q24alu_pkg::STATUS_W-1:0] status
);
  import q24alu_pkg::*;

  localparam logic [WORD_BITS-1:0] POS_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] NEG_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // Hold a stalled result word
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_value)
      && $stable(compare_true) && $stable(status))
    else $error("stalled result word changed");

  // With the output empty the pipeline has room
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output is empty");

  // A true comparison carries a zero value and ok status
  a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && compare_true |-> result_value == '0 && status == ST_OK)
    else $error("comparison result carries value or status");

  // Divide by zero saturates
  a_divz_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_DIVZ |->
      result_value == POS_MAX || result_value == NEG_MIN)
    else $error("divide by zero did not saturate");

endmodule

bind q24_8_fixed_point_alu q24alu_check #(
  .WORD_BITS (WORD_BITS)
) u_check (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .result_value (out_chan.result_value),
  .compare_true (out_chan.compare_true),
  .status       (out_chan.status)
);
